/* design/fatb_pkg.sv */
// Shared types, register indexes and codes for the fragment alpha test and blend unit.
package fatb_pkg;

    // Configuration port widths.
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 10;

    // Width of a row-major pixel index: row times width plus column.
    localparam int IDX_W = 19;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_TEST_ENABLE = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_FUNC        = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_REF         = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BLEND_ENABLE      = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BLEND_SRC         = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BLEND_DST         = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH             = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT            = 4'd7;

    // Item actions.
    localparam logic ACTION_DRAW = 1'b0;
    localparam logic ACTION_READ = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_OUTSIDE = 2'd1;
    localparam logic [1:0] STATUS_REJECT  = 2'd2;

    // Alpha compare modes.
    localparam logic [2:0] AFUNC_NEVER    = 3'd0;
    localparam logic [2:0] AFUNC_LESS     = 3'd1;
    localparam logic [2:0] AFUNC_EQUAL    = 3'd2;
    localparam logic [2:0] AFUNC_LEQUAL   = 3'd3;
    localparam logic [2:0] AFUNC_GREATER  = 3'd4;
    localparam logic [2:0] AFUNC_NOTEQUAL = 3'd5;
    localparam logic [2:0] AFUNC_GEQUAL   = 3'd6;
    localparam logic [2:0] AFUNC_ALWAYS   = 3'd7;

    // Blend factor codes.
    localparam logic [3:0] FACTOR_ZERO         = 4'd0;
    localparam logic [3:0] FACTOR_ONE          = 4'd1;
    localparam logic [3:0] FACTOR_SRC_COL      = 4'd2;
    localparam logic [3:0] FACTOR_INV_SRC_COL  = 4'd3;
    localparam logic [3:0] FACTOR_DST_COL      = 4'd4;
    localparam logic [3:0] FACTOR_INV_DST_COL  = 4'd5;
    localparam logic [3:0] FACTOR_SRC_ALPHA    = 4'd6;
    localparam logic [3:0] FACTOR_INV_SRC_ALPHA = 4'd7;
    localparam logic [3:0] FACTOR_DST_ALPHA    = 4'd8;
    localparam logic [3:0] FACTOR_INV_DST_ALPHA = 4'd9;
    localparam logic [3:0] FACTOR_SATURATE     = 4'd10;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic       alpha_test_enable;
        logic [2:0] alpha_func;
        logic [7:0] alpha_ref;
        logic       blend_enable;
        logic [3:0] blend_src;
        logic [3:0] blend_dst;
        logic [9:0] width;
        logic [8:0] height;
    } cfg_t;

endpackage

/* design/fatb_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module fatb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/fatb_cfg.sv */
// Configuration register file written through the configuration port.
module fatb_cfg
    import fatb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Registers can be written in any cycle.
    assign cfg_ready = 1'b1;

    // Select the register addressed by the word; unknown indexes are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ALPHA_TEST_ENABLE: cfg_next.alpha_test_enable = cfg_data[0];
                REG_ALPHA_FUNC:        cfg_next.alpha_func        = cfg_data[2:0];
                REG_ALPHA_REF:         cfg_next.alpha_ref         = cfg_data[7:0];
                REG_BLEND_ENABLE:      cfg_next.blend_enable      = cfg_data[0];
                REG_BLEND_SRC:         cfg_next.blend_src         = cfg_data[3:0];
                REG_BLEND_DST:         cfg_next.blend_dst         = cfg_data[3:0];
                REG_WIDTH:             cfg_next.width             = cfg_data[9:0];
                REG_HEIGHT:            cfg_next.height            = cfg_data[8:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha_test_enable <= 1'b0;
            cfg_reg.alpha_func        <= AFUNC_ALWAYS;
            cfg_reg.alpha_ref         <= 8'd0;
            cfg_reg.blend_enable      <= 1'b0;
            cfg_reg.blend_src         <= FACTOR_ONE;
            cfg_reg.blend_dst         <= FACTOR_ZERO;
            cfg_reg.width             <= 10'd320;
            cfg_reg.height            <= 9'd240;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* design/fatb_blend.sv */
// Blend datapath: factor selection and products in one stage, divide by 255 and saturate.
module fatb_blend
    import fatb_pkg::*;
(
    input  logic        clk,
    input  logic        load,
    input  cfg_t        cfg,
    input  logic [31:0] src_colour,
    input  logic [31:0] dst_colour,
    output logic [31:0] result
);

    // Blend factor for one channel; unknown codes act as one.
    function automatic logic [7:0] blend_factor(
        input logic [3:0] code,
        input logic [7:0] sa,
        input logic [7:0] da,
        input logic [7:0] sc,
        input logic [7:0] dc,
        input logic       is_alpha
    );
        logic [7:0] inv_da;
        logic [7:0] f;
        inv_da = 8'hFF - da;
        unique case (code)
            FACTOR_ZERO:          f = 8'd0;
            FACTOR_ONE:           f = 8'hFF;
            FACTOR_SRC_COL:       f = sc;
            FACTOR_INV_SRC_COL:   f = 8'hFF - sc;
            FACTOR_DST_COL:       f = dc;
            FACTOR_INV_DST_COL:   f = 8'hFF - dc;
            FACTOR_SRC_ALPHA:     f = sa;
            FACTOR_INV_SRC_ALPHA: f = 8'hFF - sa;
            FACTOR_DST_ALPHA:     f = da;
            FACTOR_INV_DST_ALPHA: f = inv_da;
            FACTOR_SATURATE:      f = is_alpha ? 8'hFF : ((sa < inv_da) ? sa : inv_da);
            default:              f = 8'hFF;
        endcase
        return f;
    endfunction

    // One lane per colour channel.
    for (genvar c = 0; c < 4; c++)
    begin : g_ch
        logic [7:0]  sc;
        logic [7:0]  dc;
        logic [7:0]  fs;
        logic [7:0]  fd;
        logic [15:0] prod_s;
        logic [15:0] prod_d;
        logic [16:0] sum_next;
        logic [16:0] sum_reg;
        logic [24:0] scaled;
        logic [8:0]  quot_est;
        logic [16:0] back;
        logic [16:0] rem;
        logic [8:0]  quot;
        logic [7:0]  blended;

        assign sc = src_colour[8*c +: 8];
        assign dc = dst_colour[8*c +: 8];
        assign fs = blend_factor(cfg.blend_src, src_colour[31:24], dst_colour[31:24],
                                 sc, dc, c == 3);
        assign fd = blend_factor(cfg.blend_dst, src_colour[31:24], dst_colour[31:24],
                                 sc, dc, c == 3);

        // Weighted sum with rounding offset.
        assign prod_s   = 16'(sc) * 16'(fs);
        assign prod_d   = 16'(dc) * 16'(fd);
        assign sum_next = {1'b0, prod_s} + {1'b0, prod_d} + 17'd127;

        always_ff @(posedge clk)
        begin
            if (load)
            begin
                sum_reg <= sum_next;
            end
        end

        // Divide by 255: the estimate v*257/65536 is exact or one short, so one
        // compare on the remainder corrects it.
        assign scaled   = {sum_reg, 8'b0} + {8'b0, sum_reg};
        assign quot_est = scaled[24:16];
        assign back     = {quot_est, 8'b0} - {8'b0, quot_est};
        assign rem      = sum_reg - back;
        assign quot     = (rem >= 17'd255) ? quot_est + 9'd1 : quot_est;
        assign blended  = (quot > 9'd255) ? 8'hFF : quot[7:0];

        // With blending off the fragment colour passes unchanged.
        assign result[8*c +: 8] = cfg.blend_enable ? blended : sc;
    end

endmodule

/* design/fragment_alpha_test_blend.sv */
// Top level of the fragment alpha test and blend unit over an RGBA8888 colour store.
//
// Fragments and pixel reads arrive on the input channel (in_valid / in_ready); each
// word gives exactly one result word on the output channel (out_valid / out_ready)
// carrying a status, the pixel as A,B,G,R bytes and the same pixel as RGB565.
// Registers are written through the configuration channel (cfg_valid / cfg_ready),
// which is always ready; write them only while no item is in flight.
// The block handles one item at a time, as each item is a read-modify-write of one store
// word: the word is accepted and the colour store is read, the blend products are formed
// in the READ state, and in the FINISH state the result is divided, saturated, written
// back and loaded into the output register, which raises out_valid. A new word is taken
// only once the sequencer is back in IDLE.
// If the receiver stalls, the finished item waits in its last stage until the output
// register frees, and no new word is accepted meanwhile.
// After reset the colour store is cleared one word per cycle, all MAX_WIDTH*MAX_HEIGHT
// words (131072 by default); in_ready stays low during that pass while configuration
// writes are taken as usual.
module fragment_alpha_test_blend
    import fatb_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   action,
    input  logic [8:0]             pos_x,
    input  logic [7:0]             pos_y,
    input  logic [7:0]             red,
    input  logic [7:0]             green,
    input  logic [7:0]             blue,
    input  logic [7:0]             alpha,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             status,
    output logic [31:0]            pixel,
    output logic [15:0]            pixel_565,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int EXT_W  = (ADDR_W + 1 > IDX_W) ? ADDR_W + 1 : IDX_W;
    localparam logic [EXT_W-1:0]  DEPTH_EXT = EXT_W'(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    typedef enum logic [1:0] {
        IDLE,
        READ,
        FINISH
    } state_t;

    // Alpha compare of the fragment against the reference.
    function automatic logic alpha_ok(
        input logic [7:0] a,
        input logic [2:0] func,
        input logic [7:0] ref_a
    );
        logic ok;
        unique case (func)
            AFUNC_NEVER:    ok = 1'b0;
            AFUNC_LESS:     ok = a < ref_a;
            AFUNC_EQUAL:    ok = a == ref_a;
            AFUNC_LEQUAL:   ok = a <= ref_a;
            AFUNC_GREATER:  ok = a > ref_a;
            AFUNC_NOTEQUAL: ok = a != ref_a;
            AFUNC_GEQUAL:   ok = a >= ref_a;
            AFUNC_ALWAYS:   ok = 1'b1;
            default:        ok = 1'b1;
        endcase
        return ok;
    endfunction

    // Pack a pixel as RGB565 with red in the top bits.
    function automatic logic [15:0] to_565(input logic [31:0] p);
        return {p[7:3], p[15:10], p[23:19]};
    endfunction

    cfg_t cfg;

    state_t state_reg;
    state_t state_next;

    logic              clear_active_reg;
    logic [ADDR_W-1:0] clear_addr_reg;

    logic              action_reg;
    logic              outside_reg;
    logic              reject_reg;
    logic [31:0]       src_reg;
    logic [31:0]       dst_reg;
    logic [ADDR_W-1:0] addr_reg;

    logic              out_valid_reg;
    logic [1:0]        status_reg;
    logic [31:0]       pixel_reg;
    logic [15:0]       pixel_565_reg;

    logic [9:0]        w_eff;
    logic [8:0]        h_eff;
    logic [17:0]       row_base;
    logic [IDX_W-1:0]  idx;
    logic [EXT_W-1:0]  idx_ext;
    logic              outside;
    logic              alpha_keep;
    logic              in_accept;
    logic              out_free;
    logic              finish;
    logic              finish_write;
    logic [31:0]       blend_pix;
    logic [31:0]       ram_rdata;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [31:0]       ram_wdata;
    logic [1:0]        res_status;
    logic [31:0]       res_pixel;

    // Configuration registers.
    fatb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Screen size clamped to the store, then the row-major index and bounds check.
    always_comb
    begin
        w_eff    = (32'(cfg.width) > 32'(MAX_WIDTH)) ? 10'(MAX_WIDTH) : cfg.width;
        h_eff    = (32'(cfg.height) > 32'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : cfg.height;
        row_base = 18'(pos_y) * 18'(w_eff);
        idx      = IDX_W'(row_base) + IDX_W'(pos_x);
        idx_ext  = EXT_W'(idx);
        outside  = ({1'b0, pos_x} >= w_eff) || ({1'b0, pos_y} >= h_eff)
                   || (idx_ext >= DEPTH_EXT);
        alpha_keep = !cfg.alpha_test_enable || alpha_ok(alpha, cfg.alpha_func, cfg.alpha_ref);
    end

    assign in_ready  = (state_reg == IDLE) && !clear_active_reg;
    assign in_accept = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign finish    = (state_reg == FINISH) && out_free;
    assign finish_write = finish && !outside_reg && (action_reg == ACTION_DRAW) && !reject_reg;

    // Item registers, captured at acceptance and after the store read.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            action_reg  <= action;
            outside_reg <= outside;
            reject_reg  <= !alpha_keep;
            src_reg     <= {alpha, blue, green, red};
            addr_reg    <= idx_ext[ADDR_W-1:0];
        end
        if (state_reg == READ)
        begin
            dst_reg <= ram_rdata;
        end
    end

    // Clearing pass over the whole store after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
        end
        else if (clear_active_reg)
        begin
            clear_addr_reg <= clear_addr_reg + ADDR_W'(1);
            if (clear_addr_reg == LAST_ADDR)
            begin
                clear_active_reg <= 1'b0;
            end
        end
    end

    // Colour store: the clearing pass and item write-back never overlap.
    assign ram_we    = clear_active_reg || finish_write;
    assign ram_waddr = clear_active_reg ? clear_addr_reg : addr_reg;
    assign ram_wdata = clear_active_reg ? 32'd0 : blend_pix;

    fatb_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_accept),
        .raddr (idx_ext[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // Blend datapath; products are registered in the read cycle.
    fatb_blend u_blend (
        .clk        (clk),
        .load       (state_reg == READ),
        .cfg        (cfg),
        .src_colour (src_reg),
        .dst_colour (state_reg == READ ? ram_rdata : dst_reg),
        .result     (blend_pix)
    );

    // Result selection, in the order the checks apply.
    always_comb
    begin
        priority if (outside_reg)
        begin
            res_status = STATUS_OUTSIDE;
            res_pixel  = 32'd0;
        end
        else if (action_reg == ACTION_READ)
        begin
            res_status = STATUS_OK;
            res_pixel  = dst_reg;
        end
        else if (reject_reg)
        begin
            res_status = STATUS_REJECT;
            res_pixel  = 32'd0;
        end
        else
        begin
            res_status = STATUS_OK;
            res_pixel  = blend_pix;
        end
    end

    // Next state of the item sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            IDLE:    if (in_accept) state_next = READ;
            READ:    state_next = FINISH;
            FINISH:  if (out_free) state_next = IDLE;
            default: state_next = IDLE;
        endcase
    end

    // Sequencer state and the output word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
            status_reg    <= STATUS_OK;
            pixel_reg     <= 32'd0;
            pixel_565_reg <= 16'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
            begin
                out_valid_reg <= 1'b1;
                status_reg    <= res_status;
                pixel_reg     <= res_pixel;
                pixel_565_reg <= (res_status == STATUS_OK) ? to_565(res_pixel) : 16'd0;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign pixel     = pixel_reg;
    assign pixel_565 = pixel_565_reg;

endmodule
